// File: hdl/dtir_pkg.sv
`timescale 1ns / 1ps

package dtir_pkg;

    localparam int TIMER_WIDTH = 16;

    typedef enum logic [2:0] {
        REQ_TICK       = 3'd0,
        REQ_WORD_WRITE = 3'd1,
        REQ_BYTE_WRITE = 3'd2,
        REQ_WORD_READ  = 3'd3,
        REQ_SET_PEND   = 3'd4
    } req_type_t;

    localparam logic [5:0] ADDR_T1_PRESCALE = 6'h00;
    localparam logic [5:0] ADDR_T1_DIVIDE   = 6'h02;
    localparam logic [5:0] ADDR_T2_PRESCALE = 6'h04;
    localparam logic [5:0] ADDR_T2_DIVIDE   = 6'h06;
    localparam logic [5:0] ADDR_TIMER_LAST  = 6'h07;
    localparam logic [5:0] ADDR_IRQ_LO      = 6'h20;
    localparam logic [5:0] ADDR_IRQ_HI      = 6'h21;
    localparam logic [5:0] ADDR_IRQ_END     = 6'h22;

    localparam int IRQ_BIT_T1 = 2;
    localparam int IRQ_BIT_T2 = 3;

    typedef struct packed {
        logic tick;
        logic wr_prescale;
        logic wr_divide;
    } tmr_ctrl_t;

    typedef struct packed {
        logic [3:0]  pad;
        logic [7:0]  interrupt_mask;
        logic        dsp_timer2_pulse;
        logic        dsp_timer1_pulse;
        logic        cpu_irq_pulse;
        logic        handled;
        logic [15:0] read_data;
    } result_t;

endpackage

// File: hdl/dtir_timer.sv
`timescale 1ns / 1ps

module dtir_timer (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  dtir_pkg::tmr_ctrl_t                ctrl,
    input  logic [dtir_pkg::TIMER_WIDTH-1:0]   wr_value,
    output logic                               fire
);

    localparam int TW = dtir_pkg::TIMER_WIDTH;

    logic [TW-1:0] prescale_value_reg, prescale_value_next;
    logic [TW-1:0] divide_value_reg, divide_value_next;
    logic [TW-1:0] prescale_count_reg, prescale_count_next;
    logic [TW-1:0] divide_count_reg, divide_count_next;
    logic          armed_reg, armed_next;

    always_comb begin
        prescale_value_next = prescale_value_reg;
        divide_value_next   = divide_value_reg;
        prescale_count_next = prescale_count_reg;
        divide_count_next   = divide_count_reg;
        armed_next          = armed_reg;
        fire                = 1'b0;
        if (ctrl.wr_prescale || ctrl.wr_divide) begin
            if (ctrl.wr_prescale) begin
                prescale_value_next = wr_value;
            end
            if (ctrl.wr_divide) begin
                divide_value_next = wr_value;
            end
            prescale_count_next = '0;
            divide_count_next   = '0;
            armed_next          = (prescale_value_next | divide_value_next) != '0;
        end else if (ctrl.tick && armed_reg) begin
            if (prescale_count_reg >= prescale_value_reg) begin
                prescale_count_next = '0;
                if (divide_count_reg >= divide_value_reg) begin
                    divide_count_next = '0;
                    fire              = 1'b1;
                    armed_next        = (prescale_value_reg | divide_value_reg) != '0;
                end else begin
                    divide_count_next = divide_count_reg + TW'(1);
                end
            end else begin
                prescale_count_next = prescale_count_reg + TW'(1);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            prescale_value_reg <= TW'(16'hFFFF);
            divide_value_reg   <= TW'(16'hFFFF);
            prescale_count_reg <= '0;
            divide_count_reg   <= '0;
            armed_reg          <= 1'b0;
        end else begin
            prescale_value_reg <= prescale_value_next;
            divide_value_reg   <= divide_value_next;
            prescale_count_reg <= prescale_count_next;
            divide_count_reg   <= divide_count_next;
            armed_reg          <= armed_next;
        end
    end

`ifndef ASSERT_OFF
    a_fire_when_armed: assert property (@(posedge aclk) disable iff (!aresetn)
        fire |-> armed_reg && ctrl.tick && (prescale_count_reg >= prescale_value_reg))
        else $error("timer fired while disarmed or before prescale wrap");
`endif

endmodule

// File: hdl/dual_interval_timer_irq_regs.sv
`timescale 1ns / 1ps

// Two interval timers with an 8-bit interrupt mask/pending register pair.
// Input words (s_axis_*) carry one request each: tuser selects tick, word
// write, byte write, word read or external set-pending; tdata carries the
// byte address, write data and the outer DSP interrupt enable.
// Every input word yields exactly one result word on m_axis_*: read data,
// handled flag, CPU interrupt pulse, both DSP timer pulses and the mask.
// Results are registered in the output register, or in the skid register
// while the receiver stalls. One word is accepted per cycle while the skid
// register is empty, so ticks then advance the timers at clock rate; the
// timers update in the accepting cycle by a compare and increment per timer.
// Reset disarms both timers, loads all prescale and divide values with
// 0xFFFF, and clears counts, mask and pending bits; s_axis_tready stays
// low while aresetn is low.
// When the receiver stalls, the result register holds its word and a
// skid register takes one more; s_axis_tready then drops until the skid
// register drains.
module dual_interval_timer_irq_regs (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    // [5:0] address, [21:6] write_data, [22] dsp_irq_enabled, [23] zero
    input  logic [23:0] s_axis_tdata,
    // [2:0] req_type
    input  logic [2:0]  s_axis_tuser,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // [15:0] read_data, [16] handled, [17] cpu_irq_pulse,
    // [18] dsp_timer1_pulse, [19] dsp_timer2_pulse, [27:20] interrupt_mask,
    // [31:28] zero
    output logic [31:0] m_axis_tdata
);

    localparam int TW = dtir_pkg::TIMER_WIDTH;

    dtir_pkg::req_type_t req;
    logic [5:0]          addr;
    logic [15:0]         wdata;
    logic                dsp_en;
    logic                accept;

    dtir_pkg::tmr_ctrl_t t1_ctrl, t2_ctrl;
    logic                fire1, fire2;

    logic [7:0]          mask_reg, mask_next;
    logic [7:0]          pending_reg, pending_next;
    dtir_pkg::result_t   res;

    logic                out_valid_reg, out_valid_next;
    dtir_pkg::result_t   out_reg, out_next;
    logic                skid_valid_reg, skid_valid_next;
    dtir_pkg::result_t   skid_reg, skid_next;

    assign req    = dtir_pkg::req_type_t'(s_axis_tuser);
    assign addr   = s_axis_tdata[5:0];
    assign wdata  = s_axis_tdata[21:6];
    assign dsp_en = s_axis_tdata[22];
    assign accept = s_axis_tvalid && s_axis_tready;

    always_comb begin
        t1_ctrl.tick        = accept && (req == dtir_pkg::REQ_TICK);
        t1_ctrl.wr_prescale = accept && (req == dtir_pkg::REQ_WORD_WRITE)
                              && (addr == dtir_pkg::ADDR_T1_PRESCALE);
        t1_ctrl.wr_divide   = accept && (req == dtir_pkg::REQ_WORD_WRITE)
                              && (addr == dtir_pkg::ADDR_T1_DIVIDE);
        t2_ctrl.tick        = t1_ctrl.tick;
        t2_ctrl.wr_prescale = accept && (req == dtir_pkg::REQ_WORD_WRITE)
                              && (addr == dtir_pkg::ADDR_T2_PRESCALE);
        t2_ctrl.wr_divide   = accept && (req == dtir_pkg::REQ_WORD_WRITE)
                              && (addr == dtir_pkg::ADDR_T2_DIVIDE);
    end

    dtir_timer u_timer1 (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .ctrl     (t1_ctrl),
        .wr_value (TW'(wdata)),
        .fire     (fire1)
    );

    dtir_timer u_timer2 (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .ctrl     (t2_ctrl),
        .wr_value (TW'(wdata)),
        .fire     (fire2)
    );

    always_comb begin
        mask_next    = mask_reg;
        pending_next = pending_reg;
        res          = '0;
        case (req)
            dtir_pkg::REQ_TICK: begin
                res.dsp_timer1_pulse = fire1;
                res.dsp_timer2_pulse = fire2;
                if (fire1 && dsp_en && mask_reg[dtir_pkg::IRQ_BIT_T1]) begin
                    pending_next[dtir_pkg::IRQ_BIT_T1] = 1'b1;
                    res.cpu_irq_pulse                  = 1'b1;
                end
                if (fire2 && dsp_en && mask_reg[dtir_pkg::IRQ_BIT_T2]) begin
                    pending_next[dtir_pkg::IRQ_BIT_T2] = 1'b1;
                    res.cpu_irq_pulse                  = 1'b1;
                end
            end
            dtir_pkg::REQ_WORD_WRITE: begin
                if (addr <= dtir_pkg::ADDR_TIMER_LAST) begin
                    res.handled = 1'b1;
                end else if (addr >= dtir_pkg::ADDR_IRQ_LO
                             && addr <= dtir_pkg::ADDR_IRQ_END) begin
                    res.handled  = 1'b1;
                    mask_next    = wdata[7:0];
                    pending_next = pending_reg & ~wdata[15:8];
                end
            end
            dtir_pkg::REQ_BYTE_WRITE: begin
                if (addr <= dtir_pkg::ADDR_TIMER_LAST) begin
                    res.handled = 1'b1;
                end else if (addr == dtir_pkg::ADDR_IRQ_LO) begin
                    res.handled  = 1'b1;
                    pending_next = pending_reg & ~wdata[7:0];
                end else if (addr == dtir_pkg::ADDR_IRQ_HI) begin
                    res.handled = 1'b1;
                    mask_next   = wdata[7:0];
                end
            end
            dtir_pkg::REQ_WORD_READ: begin
                if (addr == dtir_pkg::ADDR_IRQ_LO) begin
                    res.handled   = 1'b1;
                    res.read_data = {8'h00, pending_reg};
                end
            end
            dtir_pkg::REQ_SET_PEND: begin
                pending_next = pending_reg | wdata[7:0];
            end
            default: begin
            end
        endcase
        res.interrupt_mask = mask_next;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mask_reg    <= '0;
            pending_reg <= '0;
        end else if (accept) begin
            mask_reg    <= mask_next;
            pending_reg <= pending_next;
        end
    end

    // output register plus skid register
    always_comb begin
        out_valid_next  = out_valid_reg;
        out_next        = out_reg;
        skid_valid_next = skid_valid_reg;
        skid_next       = skid_reg;
        if (!out_valid_reg || m_axis_tready) begin
            if (skid_valid_reg) begin
                out_valid_next  = 1'b1;
                out_next        = skid_reg;
                skid_valid_next = 1'b0;
            end else begin
                out_valid_next = accept;
                out_next       = res;
            end
        end else if (accept) begin
            skid_valid_next = 1'b1;
            skid_next       = res;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end else begin
            out_valid_reg  <= out_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
        out_reg  <= out_next;
        skid_reg <= skid_next;
    end

    assign s_axis_tready = aresetn && !skid_valid_reg;
    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_reg;

`ifndef ASSERT_OFF
    a_skid_behind_out: assert property (@(posedge aclk) disable iff (!aresetn)
        skid_valid_reg |-> out_valid_reg)
        else $error("skid register full while output register empty");

    a_cpu_needs_fire: assert property (@(posedge aclk) disable iff (!aresetn)
        accept && res.cpu_irq_pulse |-> fire1 || fire2)
        else $error("CPU interrupt without a timer firing");

    a_pulse_only_tick: assert property (@(posedge aclk) disable iff (!aresetn)
        accept && (req != dtir_pkg::REQ_TICK) |-> !fire1 && !fire2)
        else $error("timer fired on a non-tick request");

    a_cpu_sets_pending: assert property (@(posedge aclk) disable iff (!aresetn)
        accept && res.cpu_irq_pulse |=>
            pending_reg[dtir_pkg::IRQ_BIT_T1] || pending_reg[dtir_pkg::IRQ_BIT_T2])
        else $error("CPU interrupt left no pending bit");
`endif

endmodule
